### rtl/core/msgt_pkg.sv
// Shared types, register indexes and reset constants for the message generation trigger.
`timescale 1ns / 1ps

package msgt_pkg;

   typedef enum logic [1:0] {
      CAUSE_NONE     = 2'd0,
      CAUSE_FIXED    = 2'd1,
      CAUSE_DYNAMICS = 2'd2,
      CAUSE_EXPIRED  = 2'd3
   } cause_type;

   localparam logic [3:0] CSR_MIN_INTERVAL  = 4'd0;
   localparam logic [3:0] CSR_MAX_INTERVAL  = 4'd1;
   localparam logic [3:0] CSR_HEADING_THR   = 4'd2;
   localparam logic [3:0] CSR_DISTANCE_THR  = 4'd3;
   localparam logic [3:0] CSR_SPEED_THR     = 4'd4;
   localparam logic [3:0] CSR_USE_CONGEST   = 4'd5;
   localparam logic [3:0] CSR_FIXED_RATE    = 4'd6;
   localparam logic [3:0] CSR_LOW_DYN_LIMIT = 4'd7;

   localparam logic [15:0] MIN_INTERVAL_RESET  = 16'd100;
   localparam logic [15:0] MAX_INTERVAL_RESET  = 16'd1000;
   localparam logic [10:0] HEADING_THR_RESET   = 11'd40;
   localparam logic [31:0] DIST_SQ_RESET       = 32'd160000;
   localparam logic [13:0] SPEED_THR_RESET     = 14'd50;
   localparam logic [7:0]  LOW_DYN_LIMIT_RESET = 8'd3;

   localparam logic [11:0] HEADING_FULL = 12'd3600;
   localparam logic [11:0] HEADING_HALF = 12'd1800;
   localparam logic [7:0]  COUNT_MAX    = 8'hFF;

   // The distance threshold is kept squared, as that is the only form the compare uses.
   typedef struct packed {
      logic [15:0] min_interval;
      logic [15:0] max_interval;
      logic [10:0] heading_thr;
      logic [31:0] distance_thr_sq;
      logic [13:0] speed_thr;
      logic        use_congestion;
      logic        fixed_rate;
      logic [7:0]  low_dyn_limit;
   } cfg_type;

   typedef struct packed {
      logic        [31:0] now_ms;
      logic        [11:0] heading;
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic signed [14:0] speed;
      logic        [15:0] congestion;
   } item_type;

   typedef struct packed {
      logic        [31:0] last_send_time;
      logic        [11:0] last_heading;
      logic signed [23:0] last_pos_x;
      logic signed [23:0] last_pos_y;
      logic signed [14:0] last_speed;
      logic        [15:0] gen_interval;
      logic        [7:0]  low_dyn_count;
   } state_type;

endpackage

### rtl/core/msgt_decide.sv
// Send decision and next tracking state for one trigger beat.
`timescale 1ns / 1ps

module msgt_decide import msgt_pkg::*; (
   input  cfg_type   cfg,
   input  item_type  item,
   input  state_type state,
   output cause_type cause,
   output state_type state_next
);

   logic [31:0] elapsed;
   logic [15:0] gap_clamp;
   logic [15:0] gap;
   logic        gap_met;
   logic [11:0] hd_raw;
   logic [11:0] hd_wrap;
   logic [11:0] hd;
   logic        heading_hit;
   logic [24:0] dx;
   logic [24:0] dy;
   logic [24:0] neg_dx;
   logic [24:0] neg_dy;
   logic [23:0] ax;
   logic [23:0] ay;
   logic [47:0] sq_x;
   logic [47:0] sq_y;
   logic [48:0] dist_sq;
   logic        distance_hit;
   logic [15:0] ds;
   logic [15:0] neg_ds;
   logic [15:0] as_speed;
   logic        speed_hit;
   logic [7:0]  count_inc;

   always_comb begin
      elapsed = item.now_ms - state.last_send_time;
      gap_clamp = (item.congestion > cfg.min_interval) ? item.congestion : cfg.min_interval;
      if (gap_clamp > cfg.max_interval) begin
         gap_clamp = cfg.max_interval;
      end
      gap = cfg.use_congestion ? gap_clamp : cfg.min_interval;
      gap_met = elapsed >= {16'd0, gap};
   end

   always_comb begin
      hd_raw = (state.last_heading > item.heading) ? state.last_heading - item.heading
                                                   : item.heading - state.last_heading;
      hd_wrap = (hd_raw >= HEADING_FULL) ? hd_raw - HEADING_FULL : hd_raw;
      hd = (hd_wrap > HEADING_HALF) ? HEADING_FULL - hd_wrap : hd_wrap;
      heading_hit = hd > {1'b0, cfg.heading_thr};
   end

   always_comb begin
      dx = {item.pos_x[23], item.pos_x} - {state.last_pos_x[23], state.last_pos_x};
      dy = {item.pos_y[23], item.pos_y} - {state.last_pos_y[23], state.last_pos_y};
      neg_dx = -dx;
      neg_dy = -dy;
      ax = dx[24] ? neg_dx[23:0] : dx[23:0];
      ay = dy[24] ? neg_dy[23:0] : dy[23:0];
      sq_x = ax * ax;
      sq_y = ay * ay;
      dist_sq = {1'b0, sq_x} + {1'b0, sq_y};
      distance_hit = dist_sq > {17'd0, cfg.distance_thr_sq};
   end

   always_comb begin
      ds = {state.last_speed[14], state.last_speed} - {item.speed[14], item.speed};
      neg_ds = -ds;
      as_speed = ds[15] ? neg_ds : ds;
      speed_hit = as_speed > {2'b00, cfg.speed_thr};
   end

   always_comb begin
      count_inc = (state.low_dyn_count != COUNT_MAX) ? state.low_dyn_count + 8'd1
                                                    : state.low_dyn_count;
      cause = CAUSE_NONE;
      state_next = state;
      if (gap_met) begin
         if (cfg.fixed_rate) begin
            cause = CAUSE_FIXED;
         end else if (heading_hit || distance_hit || speed_hit) begin
            cause = CAUSE_DYNAMICS;
            state_next.gen_interval = (elapsed < {16'd0, cfg.max_interval}) ? elapsed[15:0]
                                                                          : cfg.max_interval;
            state_next.low_dyn_count = 8'd0;
         end else if (elapsed >= {16'd0, state.gen_interval}) begin
            cause = CAUSE_EXPIRED;
            state_next.low_dyn_count = count_inc;
            if (count_inc >= cfg.low_dyn_limit) begin
               state_next.gen_interval = cfg.max_interval;
            end
         end
      end
      if (cause != CAUSE_NONE) begin
         state_next.last_send_time = item.now_ms;
         state_next.last_heading = item.heading;
         state_next.last_pos_x = item.pos_x;
         state_next.last_pos_y = item.pos_y;
         state_next.last_speed = item.speed;
      end
   end

endmodule

### rtl/core/message_generation_trigger_core.sv
// Top level of the message generation trigger: registers, beat handshake and state update.
`timescale 1ns / 1ps

// The block takes one trigger beat per clock while its input is not stalled, and returns
// one decision beat for each. The work sits between one input register and one result
// register, which a decision beat passes in that order; a stalled result holds the input
// register, and the input stalls only while both registers are full. One beat per clock
// is possible because the decision for a beat, which reads the tracking state left by
// the beat before it, is made combinationally through the heading, speed and
// squared-distance compares. Register writes may be made only while no beat is in
// flight; the distance threshold is squared as it is written.

module message_generation_trigger_core import msgt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic        [31:0] req_now_ms,
   input  logic        [11:0] req_heading_now,
   input  logic signed [23:0] req_pos_x_cm,
   input  logic signed [23:0] req_pos_y_cm,
   input  logic signed [14:0] req_speed_now,
   input  logic        [15:0] req_congestion_interval_ms,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_send_now,
   output logic        [1:0]  rsp_send_cause,
   output logic        [15:0] rsp_current_interval_ms,
   input  logic               csr_write_enable,
   input  logic        [3:0]  csr_index,
   input  logic        [15:0] csr_write_data
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   item_type    item_ff;
   logic        in_valid_ff;
   state_type   state_ff;
   state_type   state_in;
   cause_type   cause;
   logic        rsp_valid_ff;
   logic        send_now_ff;
   cause_type   cause_ff;
   logic [15:0] interval_ff;
   logic        advance;
   logic        req_accept;

   assign advance = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_MIN_INTERVAL:  cfg_in.min_interval = csr_write_data;
            CSR_MAX_INTERVAL:  cfg_in.max_interval = csr_write_data;
            CSR_HEADING_THR:   cfg_in.heading_thr = csr_write_data[10:0];
            CSR_DISTANCE_THR:  cfg_in.distance_thr_sq = csr_write_data * csr_write_data;
            CSR_SPEED_THR:     cfg_in.speed_thr = csr_write_data[13:0];
            CSR_USE_CONGEST:   cfg_in.use_congestion = csr_write_data[0];
            CSR_FIXED_RATE:    cfg_in.fixed_rate = csr_write_data[0];
            CSR_LOW_DYN_LIMIT: cfg_in.low_dyn_limit = csr_write_data[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_interval <= MIN_INTERVAL_RESET;
         cfg_ff.max_interval <= MAX_INTERVAL_RESET;
         cfg_ff.heading_thr <= HEADING_THR_RESET;
         cfg_ff.distance_thr_sq <= DIST_SQ_RESET;
         cfg_ff.speed_thr <= SPEED_THR_RESET;
         cfg_ff.use_congestion <= 1'b0;
         cfg_ff.fixed_rate <= 1'b0;
         cfg_ff.low_dyn_limit <= LOW_DYN_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   msgt_decide u_decide (
      .cfg        (cfg_ff),
      .item       (item_ff),
      .state      (state_ff),
      .cause      (cause),
      .state_next (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff.now_ms <= req_now_ms;
         item_ff.heading <= req_heading_now;
         item_ff.pos_x <= req_pos_x_cm;
         item_ff.pos_y <= req_pos_y_cm;
         item_ff.speed <= req_speed_now;
         item_ff.congestion <= req_congestion_interval_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.last_send_time <= 32'd0;
         state_ff.last_heading <= 12'd0;
         state_ff.last_pos_x <= 24'sd0;
         state_ff.last_pos_y <= 24'sd0;
         state_ff.last_speed <= 15'sd0;
         state_ff.gen_interval <= MAX_INTERVAL_RESET;
         state_ff.low_dyn_count <= 8'd0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         send_now_ff <= (cause != CAUSE_NONE);
         cause_ff <= cause;
         interval_ff <= state_in.gen_interval;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_send_now = send_now_ff;
   assign rsp_send_cause = cause_ff;
   assign rsp_current_interval_ms = interval_ff;

   // A beat that sends nothing leaves the tracking state untouched.
   assert property (@(posedge clock) disable iff (reset)
      advance && cause == CAUSE_NONE |=> $stable(state_ff))
      else $error("tracking state changed on a beat without a send");

   // A dynamics send restarts the low dynamics count.
   assert property (@(posedge clock) disable iff (reset)
      advance && cause == CAUSE_DYNAMICS |=> state_ff.low_dyn_count == 8'd0)
      else $error("low dynamics count not cleared by a dynamics send");

   // A timer send either keeps the interval or falls back to the maximum.
   assert property (@(posedge clock) disable iff (reset)
      advance && cause == CAUSE_EXPIRED |=>
         state_ff.gen_interval == $past(state_ff.gen_interval) ||
         state_ff.gen_interval == cfg_ff.max_interval)
      else $error("interval changed to an unexpected value on a timer send");

   // Every beat that leaves the input register shows up as a result beat.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("result beat missing after a decision");

   // The input side is only held off while a result is waiting.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff)
      else $error("input stalled with no result waiting");

endmodule

### tb/sv/message_generation_trigger_core_tb.sv
// Self-checking testbench for the message generation trigger core with a built-in decision predictor.
`timescale 1ns / 1ps

module message_generation_trigger_core_tb;
   import msgt_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int LONG_HOLD   = 80;
   localparam int SETTLE      = 8;
   localparam logic [15:0] DIST_THR_RESET   = 16'd400;
   localparam logic [3:0]  CSR_FIRST_UNUSED = 4'd8;

   typedef enum logic [1:0] {MOTION_STILL, MOTION_NEAR, MOTION_WILD, MOTION_MIXED} motion_type;

   typedef struct packed {
      logic [15:0] min_gap;
      logic [15:0] max_gap;
      logic [10:0] heading_thr;
      logic [15:0] distance_thr;
      logic [13:0] speed_thr;
      logic        use_congestion;
      logic        fixed_rate;
      logic [7:0]  low_dyn_limit;
   } settings_type;

   typedef struct packed {
      logic        send_now;
      cause_type   cause;
      logic [15:0] interval;
   } decision_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic        [31:0] req_now_ms = '0;
   logic        [11:0] req_heading_now = '0;
   logic signed [23:0] req_pos_x_cm = '0;
   logic signed [23:0] req_pos_y_cm = '0;
   logic signed [14:0] req_speed_now = '0;
   logic        [15:0] req_congestion_interval_ms = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_send_now;
   logic        [1:0]  rsp_send_cause;
   logic        [15:0] rsp_current_interval_ms;
   logic               csr_write_enable = 1'b0;
   logic        [3:0]  csr_index = '0;
   logic        [15:0] csr_write_data = '0;

   settings_type regs;
   state_type    track;
   decision_type decisions_due[$];

   logic        [31:0] veh_now = '0;
   logic        [11:0] veh_heading = '0;
   logic signed [23:0] veh_x = '0;
   logic signed [23:0] veh_y = '0;
   logic signed [14:0] veh_speed = '0;
   int unsigned step_lo = 0;
   int unsigned step_hi = 2000;
   int unsigned cong_hi = 2000;
   motion_type  motion = MOTION_MIXED;
   int unsigned noise_pct = 10;

   bit req_gaps_on = 1'b1;
   bit rsp_gaps_on = 1'b1;
   bit long_hold_request = 1'b0;
   int error_count = 0;
   int quiet_cycles = 0;

   message_generation_trigger_core dut (.*);

   always #2 clock = ~clock;

   function automatic settings_type make_settings(input logic [15:0] min_gap, max_gap,
         input logic [10:0] heading_thr, input logic [15:0] distance_thr,
         input logic [13:0] speed_thr, input logic use_congestion, fixed_rate,
         input logic [7:0] low_dyn_limit);
      settings_type s;
      s.min_gap = min_gap;
      s.max_gap = max_gap;
      s.heading_thr = heading_thr;
      s.distance_thr = distance_thr;
      s.speed_thr = speed_thr;
      s.use_congestion = use_congestion;
      s.fixed_rate = fixed_rate;
      s.low_dyn_limit = low_dyn_limit;
      return s;
   endfunction

   function automatic decision_type predict_decision(input item_type it);
      logic [31:0] elapsed, gap;
      logic [11:0] turn;
      logic [24:0] dx, dy;
      logic [63:0] dist_sq, thr_sq;
      logic [15:0] dv;
      logic        moved;
      decision_type d;
      elapsed = it.now_ms - track.last_send_time;
      gap = 32'(regs.min_gap);
      if (regs.use_congestion) begin
         gap = (it.congestion > regs.min_gap) ? 32'(it.congestion) : 32'(regs.min_gap);
         if (gap > 32'(regs.max_gap)) gap = 32'(regs.max_gap);
      end
      turn = (track.last_heading > it.heading) ? track.last_heading - it.heading
                                               : it.heading - track.last_heading;
      if (turn >= HEADING_FULL) turn = turn - HEADING_FULL;
      if (turn > HEADING_FULL - turn) turn = HEADING_FULL - turn;
      dx = {it.pos_x[23], it.pos_x} - {track.last_pos_x[23], track.last_pos_x};
      dy = {it.pos_y[23], it.pos_y} - {track.last_pos_y[23], track.last_pos_y};
      if (dx[24]) dx = -dx;
      if (dy[24]) dy = -dy;
      dist_sq = 64'(dx) * 64'(dx) + 64'(dy) * 64'(dy);
      thr_sq = 64'(regs.distance_thr) * 64'(regs.distance_thr);
      dv = {track.last_speed[14], track.last_speed} - {it.speed[14], it.speed};
      if (dv[15]) dv = -dv;
      moved = (turn > 12'(regs.heading_thr)) || (dist_sq > thr_sq) || (dv > 16'(regs.speed_thr));
      d.cause = CAUSE_NONE;
      if (elapsed >= gap) begin
         if (regs.fixed_rate) begin
            d.cause = CAUSE_FIXED;
         end else if (moved) begin
            d.cause = CAUSE_DYNAMICS;
            track.gen_interval = (elapsed < 32'(regs.max_gap)) ? elapsed[15:0] : regs.max_gap;
            track.low_dyn_count = '0;
         end else if (elapsed >= 32'(track.gen_interval)) begin
            d.cause = CAUSE_EXPIRED;
            if (track.low_dyn_count != COUNT_MAX) track.low_dyn_count = track.low_dyn_count + 8'd1;
            if (track.low_dyn_count >= regs.low_dyn_limit) track.gen_interval = regs.max_gap;
         end
      end
      if (d.cause != CAUSE_NONE) begin
         track.last_send_time = it.now_ms;
         track.last_heading = it.heading;
         track.last_pos_x = it.pos_x;
         track.last_pos_y = it.pos_y;
         track.last_speed = it.speed;
      end
      d.send_now = (d.cause != CAUSE_NONE);
      d.interval = track.gen_interval;
      return d;
   endfunction

   function automatic int jitter(input int unsigned lim);
      return int'($urandom_range(0, 2 * lim)) - int'(lim);
   endfunction

   function automatic item_type next_trigger();
      item_type    it;
      motion_type  m;
      int unsigned lim;
      m = motion;
      if (m == MOTION_MIXED) m = motion_type'($urandom_range(0, 2));
      if ($urandom_range(0, 99) < noise_pct) begin
         it.now_ms = $urandom;
         it.heading = 12'($urandom);
         it.pos_x = 24'($urandom);
         it.pos_y = 24'($urandom);
         it.speed = 15'($urandom);
         it.congestion = 16'($urandom);
      end else begin
         veh_now = veh_now + $urandom_range(step_lo, step_hi);
         if (m != MOTION_STILL) begin
            lim = (m == MOTION_WILD) ? 4 * regs.heading_thr + 50 : regs.heading_thr + 2;
            veh_heading = 12'((int'(veh_heading) + jitter(lim) + 3 * int'(HEADING_FULL))
                              % int'(HEADING_FULL));
            lim = (m == MOTION_WILD) ? 3 * regs.distance_thr + 50 : regs.distance_thr * 3 / 4 + 1;
            veh_x = veh_x + 24'(jitter(lim));
            veh_y = veh_y + 24'(jitter(lim));
            lim = (m == MOTION_WILD) ? 4 * regs.speed_thr + 20 : regs.speed_thr + 2;
            veh_speed = veh_speed + 15'(jitter(lim));
         end
         it.now_ms = veh_now;
         if (m != MOTION_STILL && $urandom_range(0, 19) == 0)
            it.heading = 12'($urandom_range(int'(HEADING_FULL), 4095));
         else
            it.heading = veh_heading;
         it.pos_x = veh_x;
         it.pos_y = veh_y;
         it.speed = veh_speed;
         it.congestion = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, cong_hi));
      end
      return it;
   endfunction

   function automatic settings_type random_settings();
      settings_type s;
      s.min_gap = 16'($urandom_range(0, 300));
      s.max_gap = 16'($urandom_range(0, 1500));
      s.heading_thr = ($urandom_range(0, 7) == 0) ? 11'($urandom_range(0, 1800))
                                                  : 11'($urandom_range(0, 300));
      s.distance_thr = 16'($urandom_range(0, 2000));
      s.speed_thr = 14'($urandom_range(0, 500));
      s.use_congestion = 1'($urandom);
      s.fixed_rate = ($urandom_range(0, 3) == 0);
      s.low_dyn_limit = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                    : 8'($urandom_range(1, 8));
      return s;
   endfunction

   task automatic send_trigger(input item_type it);
      if (req_gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_now_ms <= it.now_ms;
      req_heading_now <= it.heading;
      req_pos_x_cm <= it.pos_x;
      req_pos_y_cm <= it.pos_y;
      req_speed_now <= it.speed;
      req_congestion_interval_ms <= it.congestion;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decisions_due.push_back(predict_decision(it));
   endtask

   task automatic send_fields(input logic [31:0] now, input logic [11:0] heading,
         input logic signed [23:0] x, y, input logic signed [14:0] speed,
         input logic [15:0] congestion);
      item_type it;
      it.now_ms = now;
      it.heading = heading;
      it.pos_x = x;
      it.pos_y = y;
      it.speed = speed;
      it.congestion = congestion;
      send_trigger(it);
   endtask

   task automatic send_vehicle_beats(input int count);
      for (int i = 0; i < count; i++) send_trigger(next_trigger());
   endtask

   task automatic drain_decisions();
      req_valid <= 1'b0;
      while (decisions_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [3:0] index, input logic [15:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(posedge clock);
      case (index)
         CSR_MIN_INTERVAL:  regs.min_gap = data;
         CSR_MAX_INTERVAL:  regs.max_gap = data;
         CSR_HEADING_THR:   regs.heading_thr = data[10:0];
         CSR_DISTANCE_THR:  regs.distance_thr = data;
         CSR_SPEED_THR:     regs.speed_thr = data[13:0];
         CSR_USE_CONGEST:   regs.use_congestion = data[0];
         CSR_FIXED_RATE:    regs.fixed_rate = data[0];
         CSR_LOW_DYN_LIMIT: regs.low_dyn_limit = data[7:0];
         default: ;
      endcase
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_settings(input settings_type s);
      int unsigned span;
      drain_decisions();
      csr_write(CSR_MIN_INTERVAL, s.min_gap);
      csr_write(CSR_MAX_INTERVAL, s.max_gap);
      csr_write(CSR_HEADING_THR, 16'(s.heading_thr));
      csr_write(CSR_DISTANCE_THR, s.distance_thr);
      csr_write(CSR_SPEED_THR, 16'(s.speed_thr));
      csr_write(CSR_USE_CONGEST, 16'(s.use_congestion));
      csr_write(CSR_FIXED_RATE, 16'(s.fixed_rate));
      csr_write(CSR_LOW_DYN_LIMIT, 16'(s.low_dyn_limit));
      span = (s.max_gap > s.min_gap) ? s.max_gap : s.min_gap;
      if (span == 0) span = 1;
      step_lo = 0;
      step_hi = 2 * span;
      cong_hi = (step_hi > 65535) ? 65535 : step_hi;
   endtask

   task automatic test_reset_defaults();
      send_fields(32'd0, 12'd0, 24'sd0, 24'sd0, 15'sd0, 16'd0);
      send_fields(32'd99, 12'd100, 24'sd0, 24'sd0, 15'sd0, 16'hFFFF);
      send_fields(32'd100, 12'd40, 24'sd0, 24'sd0, 15'sd0, 16'd0);
      send_fields(32'd200, 12'd41, 24'sd0, 24'sd0, 15'sd0, 16'd0);
      send_fields(32'd400, 12'd3601, 24'sd0, 24'sd0, 15'sd0, 16'd0);
      send_fields(32'd500, 12'd3599, 24'sd0, 24'sd0, 15'sd0, 16'd0);
      send_fields(32'd600, 12'd3601, 24'sd400, 24'sd0, 15'sd0, 16'd0);
      send_fields(32'd800, 12'd3601, 24'sd640, 24'sd320, 15'sd0, 16'd0);
      send_fields(32'd900, 12'd3601, 24'sd640, 24'sd721, 15'sd0, 16'd0);
      send_fields(32'd1000, 12'd3601, 24'sd640, 24'sd721, 15'sd50, 16'd0);
      send_fields(32'd1100, 12'd3601, 24'sd640, 24'sd721, -15'sd1, 16'd0);
      send_fields(32'd1300, 12'd0, 24'sh800000, 24'sh7FFFFF, 15'sh4000, 16'd0);
      send_fields(32'd1500, 12'd3599, 24'sh7FFFFF, 24'sh800000, 15'sh3FFF, 16'hFFFF);
      send_fields(32'hFFFF_FFF0, 12'd3599, 24'sh7FFFFF, 24'sh800000, 15'sh3FFF, 16'd0);
      send_fields(32'h0000_0050, 12'd3599, 24'sh7FFFFF, 24'sh800000, 15'sh3FFF, 16'd0);
      send_fields(32'h0000_0054, 12'd3599, 24'sh7FFFFF, 24'sh800000, 15'sh3FFF, 16'd0);
      send_fields(32'd3000, 12'd4095, 24'sd1, 24'sd1, 15'sd0, 16'd0);
      send_fields(32'd3000, 12'd4095, 24'sd1, 24'sd1, 15'sd0, 16'd0);
   endtask

   task automatic test_register_extremes();
      motion = MOTION_MIXED;
      noise_pct = 10;
      load_settings(make_settings(16'd0, 16'd0, 11'd0, 16'd0, 14'd0, 1'b1, 1'b0, 8'd1));
      send_vehicle_beats(40);
      load_settings(make_settings(16'hFFFF, 16'hFFFF, 11'd1800, 16'hFFFF, 14'h3FFF,
                                  1'b1, 1'b0, 8'd255));
      send_vehicle_beats(40);
      // Bits above each register's width are dropped; the limit lands on zero.
      drain_decisions();
      csr_write(CSR_HEADING_THR, 16'hFFFF);
      csr_write(CSR_SPEED_THR, 16'hFFFF);
      csr_write(CSR_USE_CONGEST, 16'hFFFE);
      csr_write(CSR_FIXED_RATE, 16'hFFFE);
      csr_write(CSR_LOW_DYN_LIMIT, 16'hFF00);
      send_vehicle_beats(50);
   endtask

   task automatic test_fixed_rate();
      settings_type s;
      s = random_settings();
      s.fixed_rate = 1'b1;
      s.min_gap = 16'd50;
      load_settings(s);
      send_vehicle_beats(100);
   endtask

   task automatic test_congestion_clamp();
      settings_type s;
      s = random_settings();
      s.use_congestion = 1'b1;
      s.fixed_rate = 1'b0;
      s.min_gap = 16'd200;
      s.max_gap = 16'd100;
      load_settings(s);
      send_vehicle_beats(60);
      s.min_gap = 16'd40;
      s.max_gap = 16'd400;
      load_settings(s);
      send_vehicle_beats(100);
   endtask

   task automatic test_low_dynamics_fallback();
      settings_type s;
      s = make_settings(16'd10, 16'd60, 11'd30, 16'd200, 14'd40, 1'b0, 1'b0, 8'd2);
      noise_pct = 0;
      load_settings(s);
      motion = MOTION_WILD;
      send_vehicle_beats(3);
      motion = MOTION_STILL;
      step_lo = s.max_gap;
      send_vehicle_beats(60);
      s.low_dyn_limit = 8'd255;
      load_settings(s);
      motion = MOTION_WILD;
      send_vehicle_beats(2);
      motion = MOTION_STILL;
      step_lo = s.max_gap;
      send_vehicle_beats(280);
      motion = MOTION_MIXED;
      noise_pct = 10;
   endtask

   task automatic test_unused_index();
      drain_decisions();
      for (int i = 0; i < 8; i++) csr_write(CSR_FIRST_UNUSED + 4'(i), 16'($urandom));
      send_vehicle_beats(40);
   endtask

   task automatic test_output_backpressure();
      req_gaps_on = 1'b0;
      long_hold_request = 1'b1;
      send_vehicle_beats(60);
      req_gaps_on = 1'b1;
   endtask

   task automatic test_idle_pause();
      for (int i = 0; i < 3; i++) begin
         send_vehicle_beats(20);
         drain_decisions();
      end
   endtask

   task automatic test_random_mix();
      noise_pct = 15;
      motion = MOTION_MIXED;
      for (int i = 0; i < 7; i++) begin
         load_settings(random_settings());
         req_gaps_on = (i != 2);
         rsp_gaps_on = (i != 2) && (i != 5);
         send_vehicle_beats(100);
      end
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
   endtask

   task automatic test_steady_stream();
      load_settings(random_settings());
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      send_vehicle_beats(150);
   endtask

   initial begin : result_stall_driver
      forever begin
         @(posedge clock);
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            rsp_stall <= 1'b1;
            for (int n = 0; n < LONG_HOLD; n++) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (rsp_gaps_on && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : decision_check
      decision_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (decisions_due.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected decision beat: send=%0b cause=%0d interval=%0d",
                        rsp_send_now, rsp_send_cause, rsp_current_interval_ms);
         end else begin
            due = decisions_due.pop_front();
            if (rsp_send_now !== due.send_now || rsp_send_cause !== due.cause ||
                rsp_current_interval_ms !== due.interval) begin
               error_count++;
               if (error_count <= 10)
                  $display("decision mismatch: expected send=%0b cause=%0d interval=%0d, %s",
                           due.send_now, due.cause, due.interval,
                           $sformatf("got send=%0b cause=%0d interval=%0d", rsp_send_now,
                                     rsp_send_cause, rsp_current_interval_ms));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("message_generation_trigger_core_tb: FAIL");
      $finish;
   end

   initial begin
      regs = make_settings(MIN_INTERVAL_RESET, MAX_INTERVAL_RESET, HEADING_THR_RESET,
                           DIST_THR_RESET, SPEED_THR_RESET, 1'b0, 1'b0, LOW_DYN_LIMIT_RESET);
      track = '0;
      track.gen_interval = MAX_INTERVAL_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_register_extremes();
      test_fixed_rate();
      test_congestion_clamp();
      test_low_dynamics_fallback();
      test_unused_index();
      test_output_backpressure();
      test_idle_pause();
      test_random_mix();
      test_steady_stream();
      drain_decisions();
      if (error_count == 0 && decisions_due.size() == 0)
         $display("message_generation_trigger_core_tb: PASS");
      else
         $display("message_generation_trigger_core_tb: FAIL");
      $finish;
   end

endmodule
